FILE: hdl/bdce_pkg.sv
// Shared types and constants for the Bezier de Casteljau evaluator.
// No dependencies; imported by the controller, datapath, top level, checker and testbench.
`timescale 1ns / 1ps
package bdce_pkg;

   localparam int FRAC_BITS = 16;
   localparam int T_BITS    = 17;
   localparam logic [T_BITS-1:0] ONE_Q16 = 17'h10000;

   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_EVAL   = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic       rd_en;
      logic       first;
      logic       from_cp;
      logic       last_step;
      logic       single;
      logic       cp_wr;
      logic       t_load;
      logic       status_load;
      logic [1:0] status_code;
      logic       res_clear;
   } bdce_cmd_type;

endpackage

FILE: hdl/bdce_ctrl.sv
// Controller: point count, request decode and the level/index sequencer.
// Depends on bdce_pkg; drives bdce_datapath through a command struct.
`timescale 1ns / 1ps
module bdce_ctrl #(
   parameter int MAX_POINTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  eval_done,
   output bdce_pkg::bdce_cmd_type cmd,
   output logic [$clog2(MAX_POINTS)-1:0] dp_addr
);
   import bdce_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int GAP_W = 3;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_GAP   = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lvl_ff, lvl_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [GAP_W-1:0] gap_ff, gap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             full;
   logic             lvl_end;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign full      = (count_ff == CNT_W'(MAX_POINTS));
   assign lvl_end   = (CNT_W'(idx_ff) == (lvl_ff - 1'b1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;
      gap_in       = gap_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      dp_addr      = idx_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            dp_addr = count_ff[IDX_W-1:0];
            if (accept) begin
               cmd.status_load = 1'b1;
               cmd.res_clear   = 1'b1;
               cmd.status_code = STAT_OK;
               rsp_valid_in    = 1'b1;
               priority case (req_action)
                  ACT_APPEND: begin
                     if (full) begin
                        cmd.status_code = STAT_FULL;
                     end else begin
                        cmd.cp_wr = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ACT_EVAL: begin
                     if (count_ff == '0) begin
                        cmd.status_code = STAT_EMPTY;
                     end else begin
                        cmd.t_load   = 1'b1;
                        rsp_valid_in = 1'b0;
                        lvl_in       = count_ff;
                        idx_in       = '0;
                        state_in     = ST_ISSUE;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.rd_en     = 1'b1;
            cmd.first     = (idx_ff == '0);
            cmd.from_cp   = (lvl_ff == count_ff);
            cmd.single    = (lvl_ff == CNT_W'(1));
            cmd.last_step = (lvl_ff == CNT_W'(2)) && (idx_ff != '0);
            if (lvl_ff == CNT_W'(1)) begin
               state_in = ST_WAIT;
            end else if (lvl_end) begin
               idx_in = '0;
               lvl_in = lvl_ff - 1'b1;
               if (lvl_ff == CNT_W'(2)) begin
                  state_in = ST_WAIT;
               end else if (32'(lvl_ff) < 32'd5) begin
                  gap_in   = GAP_W'(32'd5 - 32'(lvl_ff));
                  state_in = ST_GAP;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_GAP: begin
            gap_in = gap_ff - 1'b1;
            if (gap_ff == GAP_W'(1)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_WAIT: begin
            if (eval_done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         lvl_ff       <= '0;
         idx_ff       <= '0;
         gap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lvl_ff       <= lvl_in;
         idx_ff       <= idx_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/bdce_datapath.sv
// Datapath: control point and working stores, three-stage interpolation pipe,
// result and status registers. Depends on bdce_pkg; driven by bdce_ctrl.
`timescale 1ns / 1ps
module bdce_datapath #(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bdce_pkg::bdce_cmd_type  cmd,
   input  logic [$clog2(MAX_POINTS)-1:0] dp_addr,
   input  logic [COORD_BITS-1:0]   req_point_x,
   input  logic [COORD_BITS-1:0]   req_point_y,
   input  logic [16:0]             req_t_param,
   output logic                    eval_done,
   output logic [COORD_BITS+7:0]   rsp_curve_x,
   output logic [COORD_BITS+7:0]   rsp_curve_y,
   output logic [1:0]              rsp_status
);
   import bdce_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int W     = COORD_BITS + FRAC_BITS;
   localparam int PW    = W + 1 + T_BITS + 1;

   logic [2*COORD_BITS-1:0] cp_mem_ff [MAX_POINTS];
   logic [2*W-1:0]          wk_mem_ff [MAX_POINTS];
   logic [2*COORD_BITS-1:0] cp_rd_ff;
   logic [2*W-1:0]          wk_rd_ff;

   logic [T_BITS-1:0] t_ff, t_in;

   logic             s1_valid_ff, s1_first_ff, s1_from_cp_ff, s1_last_ff, s1_single_ff;
   logic [IDX_W-1:0] s1_addr_ff;
   logic [W-1:0]     cur_x, cur_y;
   logic [W-1:0]     prev_x_ff, prev_y_ff;

   logic             s2_valid_ff, s2_last_ff;
   logic [IDX_W-1:0] s2_addr_ff;
   logic [W-1:0]     p2_x_ff, p2_y_ff;
   logic signed [W:0] diff_x_ff, diff_y_ff, diff_x_in, diff_y_in;

   logic             s3_valid_ff, s3_last_ff;
   logic [IDX_W-1:0] s3_addr_ff;
   logic [W-1:0]     p3_x_ff, p3_y_ff;
   logic signed [PW-1:0] prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   logic [W-1:0]     sum_x, sum_y;

   logic [W-1:0]     res_x_ff, res_y_ff;
   logic [1:0]       status_ff;

   assign t_in = (req_t_param > ONE_Q16) ? ONE_Q16 : req_t_param;

   always_ff @(posedge clock) begin
      if (cmd.cp_wr) begin
         cp_mem_ff[dp_addr] <= {req_point_y, req_point_x};
      end
      if (cmd.rd_en) begin
         cp_rd_ff <= cp_mem_ff[dp_addr];
         wk_rd_ff <= wk_mem_ff[dp_addr];
      end
      if (s3_valid_ff) begin
         wk_mem_ff[s3_addr_ff] <= {sum_y, sum_x};
      end
   end

   assign cur_x = s1_from_cp_ff ? {cp_rd_ff[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}
                                : wk_rd_ff[W-1:0];
   assign cur_y = s1_from_cp_ff ? {cp_rd_ff[2*COORD_BITS-1:COORD_BITS], {FRAC_BITS{1'b0}}}
                                : wk_rd_ff[2*W-1:W];

   assign diff_x_in = $signed({1'b0, cur_x}) - $signed({1'b0, prev_x_ff});
   assign diff_y_in = $signed({1'b0, cur_y}) - $signed({1'b0, prev_y_ff});
   assign prod_x_in = diff_x_ff * $signed({1'b0, t_ff});
   assign prod_y_in = diff_y_ff * $signed({1'b0, t_ff});

   assign sum_x = p3_x_ff + prod_x_ff[FRAC_BITS +: W];
   assign sum_y = p3_y_ff + prod_y_ff[FRAC_BITS +: W];

   always_ff @(posedge clock) begin
      if (cmd.t_load) begin
         t_ff <= t_in;
      end
      s1_first_ff   <= cmd.first;
      s1_from_cp_ff <= cmd.from_cp;
      s1_last_ff    <= cmd.last_step;
      s1_single_ff  <= cmd.single;
      s1_addr_ff    <= dp_addr;
      if (s1_valid_ff) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      s2_last_ff <= s1_last_ff;
      s2_addr_ff <= s1_addr_ff - 1'b1;
      p2_x_ff    <= prev_x_ff;
      p2_y_ff    <= prev_y_ff;
      diff_x_ff  <= diff_x_in;
      diff_y_ff  <= diff_y_in;
      s3_last_ff <= s2_last_ff;
      s3_addr_ff <= s2_addr_ff;
      p3_x_ff    <= p2_x_ff;
      p3_y_ff    <= p2_y_ff;
      prod_x_ff  <= prod_x_in;
      prod_y_ff  <= prod_y_in;
      if (cmd.status_load) begin
         status_ff <= cmd.status_code;
      end
      if (cmd.res_clear) begin
         res_x_ff <= '0;
         res_y_ff <= '0;
      end else if (s1_valid_ff && s1_single_ff) begin
         res_x_ff <= cur_x;
         res_y_ff <= cur_y;
      end else if (s3_valid_ff && s3_last_ff) begin
         res_x_ff <= sum_x;
         res_y_ff <= sum_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff && !s1_first_ff && !s1_single_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign eval_done   = (s1_valid_ff && s1_single_ff) || (s3_valid_ff && s3_last_ff);
   assign rsp_curve_x = res_x_ff[W-1:8];
   assign rsp_curve_y = res_y_ff[W-1:8];
   assign rsp_status  = status_ff;

endmodule

FILE: hdl/bezier_de_casteljau_evaluator_core.sv
// Bezier de Casteljau evaluator, top level.
// Depends on bdce_pkg, bdce_ctrl and bdce_datapath.
//
// Request channel (req_*): one item per transfer. Action append stores
// (point_x, point_y), clear empties the store, evaluate computes the curve at
// t_param (Q1.16, values above 1.0 saturate). Every request gives exactly one
// response transfer on rsp_*: curve_x/curve_y in Q(COORD_BITS).8 and a status.
// Append, clear, full and empty responses appear in the cycle after the request.
// An evaluate reads one store entry per cycle outside the short-level wait
// states, one read per point of each de Casteljau level, into a three-stage
// subtract/multiply/add pipe. Short levels (three or four points) insert
// wait states so the pipe writes back before the next level reads. A single
// stored point is answered from the store read, bypassing the pipe.
// One request is in work at a time; req_ready is high only while the block is
// idle and the response register is empty or being taken in the same cycle.
// When the receiver stalls, the response holds and no new request is taken.
// Reset empties the point store and drops any pending response.
`timescale 1ns / 1ps
module bezier_de_casteljau_evaluator_core #(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [COORD_BITS-1:0] req_point_x,
   input  logic [COORD_BITS-1:0] req_point_y,
   input  logic [16:0]           req_t_param,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS+7:0] rsp_curve_x,
   output logic [COORD_BITS+7:0] rsp_curve_y,
   output logic [1:0]            rsp_status
);
   import bdce_pkg::*;

   bdce_cmd_type                  cmd;
   logic [$clog2(MAX_POINTS)-1:0] dp_addr;
   logic                          eval_done;

   bdce_ctrl #(
      .MAX_POINTS(MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_action(req_action),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .eval_done (eval_done),
      .cmd       (cmd),
      .dp_addr   (dp_addr)
   );

   bdce_datapath #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_addr    (dp_addr),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_t_param(req_t_param),
      .eval_done  (eval_done),
      .rsp_curve_x(rsp_curve_x),
      .rsp_curve_y(rsp_curve_y),
      .rsp_status (rsp_status)
   );

endmodule

FILE: hdl/bdce_checker.sv
// Port-level checker for the Bezier evaluator top level, with its bind.
// Depends on bdce_pkg and bezier_de_casteljau_evaluator_core.
`timescale 1ns / 1ps
module bdce_checker #(
   parameter int COORD_BITS = 10
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [1:0]            req_action,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS+7:0] rsp_curve_x,
   input logic [COORD_BITS+7:0] rsp_curve_y,
   input logic [1:0]            rsp_status
);
   import bdce_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_curve_x) && $stable(rsp_curve_y))
      else $error("stalled response changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid && !rsp_ready))
      else $error("request taken while response is stalled");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action != ACT_EVAL |=> rsp_valid)
      else $error("non-evaluate request without next-cycle response");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_curve_x == '0 && rsp_curve_y == '0)
      else $error("curve nonzero on error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_FULL
         || rsp_status == STAT_EMPTY)
      else $error("undefined status code");

endmodule

bind bezier_de_casteljau_evaluator_core bdce_checker #(
   .COORD_BITS(COORD_BITS)
) u_bdce_checker (.*);

FILE: dv/tb_top.sv
// Testbench for bezier_de_casteljau_evaluator_core: directed table, then random curve bursts.
// Checks every response against its typed table row or a fixed-point de Casteljau predictor; depends on bdce_pkg.
`timescale 1ns / 1ps
module tb_top;
   import bdce_pkg::*;

   localparam int MAX_PTS      = 16;
   localparam int COORD_W      = 10;
   localparam int OUT_W        = COORD_W + 8;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 188;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic [1:0]       status;
   } curve_result_type;

   typedef struct {
      logic [1:0]         action;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [T_BITS-1:0]  t;
      int                 reps;
      bit                 typed;
      curve_result_type   res;
   } vec_row_type;

   localparam int N_VEC = 27;
   vec_row_type vec_table [N_VEC] = '{
      '{ACT_EVAL,   10'd0,    10'd0,    17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_EMPTY}},
      '{ACT_UNUSED, 10'd1023, 10'd1023, 17'h1ffff,  1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_CLEAR,  10'd0,    10'd0,    17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_APPEND, 10'd1023, 10'd0,    17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd12345,  1,  1'b1, '{18'd261888, 18'd0, STAT_OK}},
      '{ACT_APPEND, 10'd0,    10'd1023, 17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd0,      1,  1'b1, '{18'd261888, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd65536,  1,  1'b1, '{18'd0, 18'd261888, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'h1ffff,  1,  1'b1, '{18'd0, 18'd261888, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd65537,  1,  1'b1, '{18'd0, 18'd261888, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd32768,  1,  1'b0, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd1,      1,  1'b0, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd65535,  1,  1'b0, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_APPEND, 10'd0,    10'd0,    17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd21845,  1,  1'b0, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_APPEND, 10'd1023, 10'd1023, 17'd0,      13, 1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_APPEND, 10'd512,  10'd512,  17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_FULL}},
      '{ACT_UNUSED, 10'd0,    10'd0,    17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd32768,  1,  1'b0, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd1,      1,  1'b0, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd65535,  1,  1'b0, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd0,      1,  1'b1, '{18'd261888, 18'd0, STAT_OK}},
      '{ACT_CLEAR,  10'd0,    10'd0,    17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd40000,  1,  1'b1, '{18'd0, 18'd0, STAT_EMPTY}},
      '{ACT_APPEND, 10'd682,  10'd341,  17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_APPEND, 10'd341,  10'd682,  17'd0,      1,  1'b1, '{18'd0, 18'd0, STAT_OK}},
      '{ACT_EVAL,   10'd0,    10'd0,    17'd43690,  1,  1'b0, '{18'd0, 18'd0, STAT_OK}}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_action = ACT_APPEND;
   logic [COORD_W-1:0]   req_point_x = '0;
   logic [COORD_W-1:0]   req_point_y = '0;
   logic [T_BITS-1:0]    req_t_param = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_W-1:0]     rsp_curve_x;
   logic [OUT_W-1:0]     rsp_curve_y;
   logic [1:0]           rsp_status;

   logic [COORD_W-1:0]   ctl_x [MAX_PTS];
   logic [COORD_W-1:0]   ctl_y [MAX_PTS];
   int                   ctl_count = 0;
   curve_result_type     expected_curves [$];
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   items_sent = 0;
   int                   fail_count = 0;
   int                   cycle_count = 0;

   bezier_de_casteljau_evaluator_core #(
      .MAX_POINTS(MAX_PTS),
      .COORD_BITS(COORD_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_t_param(req_t_param),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_curve_x(rsp_curve_x),
      .rsp_curve_y(rsp_curve_y),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic curve_result_type bezier_predict(input logic [1:0] act,
                                                       input logic [COORD_W-1:0] px,
                                                       input logic [COORD_W-1:0] py,
                                                       input logic [T_BITS-1:0] t_in);
      curve_result_type res;
      longint wx [MAX_PTS];
      longint wy [MAX_PTS];
      longint t;
      int lvl;
      res.x = '0;
      res.y = '0;
      res.status = STAT_OK;
      t = (t_in > ONE_Q16) ? longint'(ONE_Q16) : longint'(t_in);
      case (act)
         ACT_APPEND: begin
            if (ctl_count >= MAX_PTS) begin
               res.status = STAT_FULL;
            end else begin
               ctl_x[ctl_count] = px;
               ctl_y[ctl_count] = py;
               ctl_count++;
            end
         end
         ACT_EVAL: begin
            if (ctl_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               for (int i = 0; i < ctl_count; i++) begin
                  wx[i] = longint'(ctl_x[i]) <<< FRAC_BITS;
                  wy[i] = longint'(ctl_y[i]) <<< FRAC_BITS;
               end
               for (lvl = ctl_count; lvl > 1; lvl--) begin
                  for (int i = 0; i < lvl - 1; i++) begin
                     // floor the scaled difference, matching two's-complement truncation
                     wx[i] = wx[i] + ((t * (wx[i+1] - wx[i])) >>> FRAC_BITS);
                     wy[i] = wy[i] + ((t * (wy[i+1] - wy[i])) >>> FRAC_BITS);
                  end
               end
               res.x = OUT_W'(wx[0] >>> 8);
               res.y = OUT_W'(wy[0] >>> 8);
            end
         end
         ACT_CLEAR: begin
            ctl_count = 0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic send_row(input vec_row_type row);
      curve_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= row.action;
      req_point_x <= row.px;
      req_point_y <= row.py;
      req_t_param <= row.t;
      do @(posedge clock); while (!req_ready);
      res = bezier_predict(row.action, row.px, row.py, row.t);
      if (row.typed)
         res = row.res;
      expected_curves = {expected_curves, res};
      items_sent++;
   endtask

   function automatic logic [COORD_W-1:0] rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 8)
         return '0;
      if (r < 16)
         return '1;
      return COORD_W'($urandom_range((1 << COORD_W) - 1));
   endfunction

   function automatic logic [T_BITS-1:0] rand_t();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return '0;
      if (r < 20)
         return ONE_Q16;
      if (r < 28)
         return T_BITS'($urandom_range(131071, 65537));
      if (r < 34)
         return T_BITS'($urandom_range(3, 1));
      if (r < 40)
         return ONE_Q16 - T_BITS'(1);
      return T_BITS'($urandom_range(65536));
   endfunction

   function automatic vec_row_type rand_row(input logic [1:0] act);
      vec_row_type row;
      row.action = act;
      row.px     = rand_coord();
      row.py     = rand_coord();
      row.t      = rand_t();
      row.reps   = 1;
      row.typed  = 1'b0;
      row.res    = '{'0, '0, STAT_OK};
      return row;
   endfunction

   always @(posedge clock) begin : rsp_check
      curve_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_curves.size() == 0) begin
               $error("unexpected response: curve_x %0d curve_y %0d status %0d",
                      rsp_curve_x, rsp_curve_y, rsp_status);
               fail_count++;
            end else begin
               want = expected_curves.pop_front();
               if (rsp_curve_x !== want.x) begin
                  $error("curve_x: expected %0d, actual %0d", want.x, rsp_curve_x);
                  fail_count++;
               end
               if (rsp_curve_y !== want.y) begin
                  $error("curve_y: expected %0d, actual %0d", want.y, rsp_curve_y);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin : stimulus
      int idle_set [4];
      int stall_set [4];
      int n_append;
      int n_eval;
      idle_set  = '{0, 48, 0, 20};
      stall_set = '{0, 0, 48, 20};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vec_table[k]) begin
         repeat (vec_table[k].reps) send_row(vec_table[k]);
      end

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         rsp_stall_pct = stall_set[p];
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            // start a fresh curve most of the time, otherwise keep growing toward full
            if ($urandom_range(99) < 60)
               send_row(rand_row(ACT_CLEAR));
            if ($urandom_range(99) < 15)
               send_row(rand_row(ACT_EVAL));
            n_append = ($urandom_range(99) < 70) ? $urandom_range(8, 1) : $urandom_range(18, 9);
            for (int i = 0; i < n_append; i++) begin
               send_row(rand_row(ACT_APPEND));
               if ($urandom_range(99) < 4)
                  send_row(rand_row(ACT_UNUSED));
               else if ($urandom_range(99) < 5)
                  send_row(rand_row(ACT_EVAL));
            end
            n_eval = $urandom_range(4, 1);
            repeat (n_eval) send_row(rand_row(ACT_EVAL));
         end
      end

      req_valid <= 1'b0;
      while (expected_curves.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/bdce_pkg.sv
hdl/bdce_ctrl.sv
hdl/bdce_datapath.sv
hdl/bezier_de_casteljau_evaluator_core.sv
hdl/bdce_checker.sv
dv/tb_top.sv
